// ----- rtl/core/efsd_pkg.sv -----
package efsd_pkg;

  localparam int MAX_SERVERS = 16;
  localparam int SIDX_W      = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

  localparam int NUM_W     = 5;
  localparam int TOD_W     = 17;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int ARR_W     = 17;
  localparam int SVC_W     = 14;
  localparam int TIME_W    = 32;
  localparam int TOTAL_W   = 48;
  localparam int COUNT_W   = 16;
  localparam int IDX_OUT_W = 4;

  localparam logic [ARR_W-1:0] SECS_PER_HOUR = ARR_W'(3600);
  localparam logic [ARR_W-1:0] SECS_PER_MIN  = ARR_W'(60);
  localparam logic [SVC_W-1:0] SVC_PER_MIN   = SVC_W'(60);

  localparam logic [NUM_W-1:0] NUM_RESET   = NUM_W'(1);
  localparam logic [TOD_W-1:0] OPEN_RESET  = TOD_W'(8 * 3600);
  localparam logic [TOD_W-1:0] CLOSE_RESET = TOD_W'(17 * 3600);

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SERVERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TIME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TIME  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_LAST,
    S_CALC,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       new_day;
    logic [4:0] arrive_hour;
    logic [5:0] arrive_minute;
    logic [5:0] arrive_second;
    logic [7:0] service_minutes;
  } in_item_t;

  typedef struct packed {
    logic                 served;
    logic [IDX_OUT_W-1:0] server_index;
    logic [TIME_W-1:0]    wait_seconds;
    logic [TOTAL_W-1:0]   total_wait_seconds;
    logic [COUNT_W-1:0]   served_count;
  } out_item_t;

endpackage

// ----- rtl/core/efsd_ram.sv -----
module efsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/earliest_free_server_dispatch.sv -----
// Channel  Direction  Handshake                Payload
// in_      input      in_valid / in_ready      in_item  (efsd_pkg::in_item_t)
// out_     output     out_valid / out_ready    out_item (efsd_pkg::out_item_t)
// cfg_     input      cfg_we                   cfg_idx, cfg_wdata
//
// A served item runs through prep, a scan of the n servers in use, last, calc,
// write and done before the next accept; the free-time memory gives one entry per
// cycle to the minimum scan. An item after closing goes from prep to done.
// Reset is synchronous and clears the per-server valid bits; no clearing pass.
// A stalled output register holds; the next item runs until its result is due.
module earliest_free_server_dispatch (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  efsd_pkg::in_item_t                       in_item,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output efsd_pkg::out_item_t                      out_item,
  input  logic                                     cfg_we,
  input  logic [efsd_pkg::CFG_IDX_W-1:0]           cfg_idx,
  input  logic [efsd_pkg::CFG_W-1:0]               cfg_wdata
);
  import efsd_pkg::*;

  state_t state_r, state_nxt;

  logic [NUM_W-1:0]       num_r;
  logic [TOD_W-1:0]       open_r;
  logic [TOD_W-1:0]       close_r;
  logic [TOD_W-1:0]       day_open_r;

  in_item_t               item_r;
  logic [ARR_W-1:0]       arrive_r;
  logic [SVC_W-1:0]       svc_r;
  logic                   closed_r;
  logic                   serve_r;
  logic [MAX_SERVERS-1:0] vld_r;

  logic [SIDX_W-1:0]      scan_idx_r;
  logic [SIDX_W-1:0]      rd_idx_r;
  logic                   rd_pend_r;
  logic [SIDX_W-1:0]      best_idx_r;
  logic [TIME_W-1:0]      best_time_r;

  logic [TIME_W-1:0]      wait_r;
  logic [TIME_W-1:0]      next_r;
  logic [TOTAL_W-1:0]     total_r;
  logic [COUNT_W-1:0]     count_r;

  out_item_t              out_r;
  logic                   out_valid_r;

  logic [SIDX_W-1:0]      last_idx;
  logic [ARR_W-1:0]       arrive_c;
  logic [SVC_W-1:0]       svc_c;
  logic                   closed_eff;
  logic                   closed_c;
  logic [TIME_W-1:0]      ram_rdata;
  logic [TIME_W-1:0]      rd_time;
  logic                   take_c;
  logic                   busy_c;
  logic [TIME_W-1:0]      base_c;
  logic [TIME_W:0]        next_c;
  logic [TOTAL_W:0]       total_sum;
  logic                   ram_we;
  logic                   out_load;
  logic                   scan_en;

  always_comb begin
    if (num_r == '0) begin
      last_idx = '0;
    end else if (32'(num_r) > MAX_SERVERS) begin
      last_idx = SIDX_W'(MAX_SERVERS - 1);
    end else begin
      last_idx = SIDX_W'(num_r - NUM_W'(1));
    end
  end

  assign arrive_c = ARR_W'(item_r.arrive_hour) * SECS_PER_HOUR
                  + ARR_W'(item_r.arrive_minute) * SECS_PER_MIN
                  + ARR_W'(item_r.arrive_second);
  assign svc_c    = SVC_W'(item_r.service_minutes) * SVC_PER_MIN;

  assign closed_eff = closed_r && !item_r.new_day;
  assign closed_c   = closed_eff || (arrive_c > close_r);

  assign rd_time = vld_r[rd_idx_r] ? ram_rdata : TIME_W'(day_open_r);
  assign take_c  = (rd_idx_r == '0) || (rd_time < best_time_r);

  assign busy_c    = best_time_r > TIME_W'(arrive_r);
  assign base_c    = busy_c ? best_time_r : TIME_W'(arrive_r);
  assign next_c    = {1'b0, base_c} + (TIME_W + 1)'(svc_r);
  assign total_sum = {1'b0, total_r} + (TOTAL_W + 1)'(wait_r);

  efsd_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_SERVERS)
  ) u_free_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (best_idx_r),
    .wdata (next_r),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        state_nxt = closed_c ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        if (scan_idx_r == last_idx) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST:  state_nxt = S_CALC;
      S_CALC:  state_nxt = S_WRITE;
      S_WRITE: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ram_we   = 1'b0;
    scan_en  = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_SCAN:  scan_en  = 1'b1;
      S_WRITE: ram_we   = 1'b1;
      S_DONE:  out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      num_r      <= NUM_RESET;
      open_r     <= OPEN_RESET;
      close_r    <= CLOSE_RESET;
      day_open_r <= OPEN_RESET;
      vld_r      <= '0;
      closed_r   <= 1'b0;
      total_r    <= '0;
      count_r    <= '0;
      rd_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= scan_en;

      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_NUM_SERVERS: num_r   <= cfg_wdata[NUM_W-1:0];
          CFG_OPEN_TIME:   open_r  <= cfg_wdata[TOD_W-1:0];
          CFG_CLOSE_TIME:  close_r <= cfg_wdata[TOD_W-1:0];
          default: ;
        endcase
      end

      if (state_r == S_PREP) begin
        if (item_r.new_day) begin
          vld_r      <= '0;
          total_r    <= '0;
          count_r    <= '0;
          day_open_r <= open_r;
        end
        closed_r <= closed_c;
      end

      if (ram_we) begin
        vld_r[best_idx_r] <= 1'b1;
        total_r <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
        if (count_r != '1) begin
          count_r <= count_r + COUNT_W'(1);
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end

    if (state_r == S_PREP) begin
      arrive_r   <= arrive_c;
      svc_r      <= svc_c;
      serve_r    <= !closed_c;
      scan_idx_r <= '0;
    end else if (scan_en) begin
      scan_idx_r <= scan_idx_r + SIDX_W'(1);
    end

    if (scan_en) begin
      rd_idx_r <= scan_idx_r;
    end

    if (rd_pend_r && take_c) begin
      best_idx_r  <= rd_idx_r;
      best_time_r <= rd_time;
    end

    if (state_r == S_CALC) begin
      wait_r <= busy_c ? (best_time_r - TIME_W'(arrive_r)) : '0;
      next_r <= next_c[TIME_W] ? '1 : next_c[TIME_W-1:0];
    end

    if (out_load) begin
      out_r.served             <= serve_r;
      out_r.server_index       <= serve_r ? IDX_OUT_W'(best_idx_r) : '0;
      out_r.wait_seconds       <= serve_r ? wait_r : '0;
      out_r.total_wait_seconds <= total_r;
      out_r.served_count       <= count_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- rtl/core/efsd_chk.sv -----
module efsd_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input efsd_pkg::out_item_t out_item
);
  import efsd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again during item processing");

  a_unserved_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.served |->
      out_item.wait_seconds == '0 && out_item.server_index == '0)
    else $error("unserved item carries a wait or server");

  a_served_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.served |->
      out_item.served_count != '0 &&
      out_item.total_wait_seconds >= TOTAL_W'(out_item.wait_seconds))
    else $error("served item not reflected in totals");

endmodule

bind earliest_free_server_dispatch efsd_chk u_efsd_chk (.*);

// ----- dv/tb_earliest_free_server_dispatch.sv -----
`timescale 1ns / 1ps

module tb_earliest_free_server_dispatch;
  import efsd_pkg::*;

  localparam int LIMIT      = 3_000_000;
  localparam int PHASES     = 8;
  localparam int PHASE_JOBS = 170;
  localparam int SETTLE     = 32;
  localparam int DRAIN      = 40;
  localparam int LAST_TIME  = 31 * 3600 + 59 * 60 + 59;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  earliest_free_server_dispatch u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  typedef struct {
    in_item_t  job;
    bit        fixed;
    out_item_t res;
  } step_t;

  logic [NUM_W-1:0]   cfg_servers;
  logic [TOD_W-1:0]   cfg_open;
  logic [TOD_W-1:0]   cfg_close;
  logic [TIME_W-1:0]  free_at [MAX_SERVERS];
  logic [TOTAL_W-1:0] wait_sum;
  logic [COUNT_W-1:0] jobs_done;
  bit                 day_closed;

  out_item_t pending_dispatch_q[$];
  step_t     steps[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        cycles = 0;
  int        idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void start_day();
    foreach (free_at[i]) free_at[i] = 32'(cfg_open);
    wait_sum   = '0;
    jobs_done  = '0;
    day_closed = 1'b0;
  endfunction

  function automatic out_item_t dispatch_job(input in_item_t job);
    out_item_t  r;
    int         n;
    int         pick;
    int         i;
    bit [63:0]  arrival;
    bit [63:0]  svc_s;
    bit [63:0]  fin;
    bit [63:0]  wt;
    bit [63:0]  nxt;
    bit [63:0]  sum;
    if (job.new_day) start_day();
    arrival = 64'(job.arrive_hour) * 64'd3600 + 64'(job.arrive_minute) * 64'd60
            + 64'(job.arrive_second);
    svc_s = 64'(job.service_minutes) * 64'd60;
    if (!day_closed && arrival > 64'(cfg_close)) day_closed = 1'b1;
    r = '0;
    if (day_closed) begin
      r.total_wait_seconds = wait_sum;
      r.served_count       = jobs_done;
      return r;
    end
    n = int'(cfg_servers);
    if (n == 0) n = 1;
    if (n > MAX_SERVERS) n = MAX_SERVERS;
    pick = 0;
    for (i = 1; i < n; i++) begin
      if (free_at[i] < free_at[pick]) pick = i;
    end
    fin = 64'(free_at[pick]);
    if (fin > arrival) begin
      wt  = fin - arrival;
      nxt = fin + svc_s;
    end else begin
      wt  = '0;
      nxt = arrival + svc_s;
    end
    if (nxt > 64'hFFFF_FFFF) nxt = 64'hFFFF_FFFF;
    free_at[pick] = nxt[31:0];
    sum = {16'd0, wait_sum} + wt;
    if (sum > 64'hFFFF_FFFF_FFFF) sum = 64'hFFFF_FFFF_FFFF;
    wait_sum = sum[47:0];
    if (jobs_done != 16'hFFFF) jobs_done++;
    r.served             = 1'b1;
    r.server_index       = 4'(pick);
    r.wait_seconds       = wt[31:0];
    r.total_wait_seconds = wait_sum;
    r.served_count       = jobs_done;
    return r;
  endfunction

  task automatic add_step(input bit nd, input int h, input int m, input int s, input int svc,
                          input bit fixed, input bit sv, input int idx, input longint wt,
                          input longint tot, input int cnt);
    step_t st;
    st.job.new_day             = nd;
    st.job.arrive_hour         = 5'(h);
    st.job.arrive_minute       = 6'(m);
    st.job.arrive_second       = 6'(s);
    st.job.service_minutes     = 8'(svc);
    st.fixed                   = fixed;
    st.res.served              = sv;
    st.res.server_index        = 4'(idx);
    st.res.wait_seconds        = 32'(wt);
    st.res.total_wait_seconds  = 48'(tot);
    st.res.served_count        = 16'(cnt);
    steps.insert(steps.size(), st);
  endtask

  task automatic push_job(input in_item_t job, input bit fixed, input out_item_t fixed_res);
    out_item_t predicted;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_item  <= job;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = dispatch_job(job);
    pending_dispatch_q.insert(pending_dispatch_q.size(), fixed ? fixed_res : predicted);
    @(negedge clk);
  endtask

  task automatic configure(input logic [NUM_W-1:0] ns, input logic [TOD_W-1:0] op,
                           input logic [TOD_W-1:0] cl);
    in_valid <= 1'b0;
    while (pending_dispatch_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_NUM_SERVERS;
    cfg_wdata <= CFG_W'(ns);
    @(negedge clk);
    cfg_idx   <= CFG_OPEN_TIME;
    cfg_wdata <= op;
    @(negedge clk);
    cfg_idx   <= CFG_CLOSE_TIME;
    cfg_wdata <= cl;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_servers = ns;
    cfg_open    = op;
    cfg_close   = cl;
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_dispatch_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d unexpected: served=%0b server=%0d wait=%0d total=%0d count=%0d",
                   results_seen, out_item.served, out_item.server_index,
                   out_item.wait_seconds, out_item.total_wait_seconds, out_item.served_count);
      end else begin
        want = pending_dispatch_q.pop_front();
        if (out_item.served !== want.served ||
            out_item.server_index !== want.server_index ||
            out_item.wait_seconds !== want.wait_seconds ||
            out_item.total_wait_seconds !== want.total_wait_seconds ||
            out_item.served_count !== want.served_count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d exp: served=%0b server=%0d wait=%0d total=%0d count=%0d",
                     results_seen, want.served, want.server_index, want.wait_seconds,
                     want.total_wait_seconds, want.served_count);
            $display("result %0d got: served=%0b server=%0d wait=%0d total=%0d count=%0d",
                     results_seen, out_item.served, out_item.server_index,
                     out_item.wait_seconds, out_item.total_wait_seconds, out_item.served_count);
          end
        end
      end
    end
  end

  initial begin : stimulus
    in_item_t      job;
    logic [31:0]   raw;
    logic [4:0]    ns;
    logic [16:0]   op;
    logic [16:0]   cl;
    int            t;
    int            day_left;
    int            open_s;
    int            r;
    int            svc;
    bit            nd;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_NUM_SERVERS;
    cfg_wdata   = '0;
    cfg_servers = NUM_RESET;
    cfg_open    = OPEN_RESET;
    cfg_close   = CLOSE_RESET;
    start_day();

    //        nd  h   m   s  svc fix sv idx   wait   total cnt
    add_step(0,  8,  0,  0,   0, 1, 1, 0,     0,     0, 1);
    add_step(0,  7,  0,  0,  10, 1, 1, 0,  3600,  3600, 2);
    add_step(0,  0,  0,  0, 255, 0, 0, 0,     0,     0, 0);
    add_step(0, 17,  0,  0,   0, 0, 0, 0,     0,     0, 0);
    add_step(0, 17,  0,  1,   1, 0, 0, 0,     0,     0, 0);
    add_step(0,  0,  0,  0,   0, 0, 0, 0,     0,     0, 0);
    add_step(1,  0,  0,  0,   0, 1, 1, 0, 28800, 28800, 1);
    add_step(0, 31, 63, 63, 255, 1, 0, 0,     0, 28800, 1);
    add_step(1, 31, 63, 63,   0, 1, 0, 0,     0,     0, 0);
    add_step(1, 23, 59, 59, 255, 1, 0, 0,     0,     0, 0);
    add_step(1,  0,  0,  0,   0, 1, 1, 0, 28800, 28800, 1);
    add_step(0, 16, 59, 59, 255, 1, 1, 0,     0, 28800, 2);
    add_step(0, 16, 60,  0,   0, 0, 0, 0,     0,     0, 0);
    add_step(1,  0,  0, 63, 128, 0, 0, 0,     0,     0, 0);
    add_step(0,  0, 63,  0,   1, 0, 0, 0,     0,     0, 0);
    add_step(0, 16, 59, 60,   0, 0, 0, 0,     0,     0, 0);
    add_step(0, 16, 32, 32,  85, 0, 0, 0,     0,     0, 0);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_pct = 10;
    foreach (steps[i]) push_job(steps[i].job, steps[i].fixed, steps[i].res);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin ns = 5'd16; op = 17'd0;      cl = 17'h1FFFF; end
        1: begin ns = 5'd0;  op = 17'h1FFFF;  cl = 17'd0;     end
        2: begin ns = 5'd31; op = 17'd86399;  cl = 17'd86399; end
        3: begin ns = 5'd17; op = OPEN_RESET; cl = CLOSE_RESET; end
        4: begin
          ns = 5'($urandom_range(1, 16));
          op = 17'($urandom_range(0, 86399));
          cl = 17'($urandom_range(0, 86399));
        end
        default: begin
          ns = 5'($urandom_range(2, 16));
          op = 17'($urandom_range(0, 43200));
          cl = 17'($urandom_range(36000, 86399));
        end
      endcase
      configure(ns, op, cl);
      case (p % 3)
        0:       idle_pct = 25;
        1:       idle_pct = 0;
        default: idle_pct = 8;
      endcase
      open_s   = int'(cfg_open);
      day_left = 0;
      t        = 0;
      repeat (PHASE_JOBS) begin
        if ($urandom_range(0, 9) == 0) begin
          raw = $urandom;
          job = raw[$bits(in_item_t)-1:0];
        end else begin
          if (day_left == 0) begin
            day_left = $urandom_range(4, 60);
            nd       = ($urandom_range(0, 7) != 0);
            if ($urandom_range(0, 1) == 1 && open_s <= LAST_TIME)
              t = open_s - $urandom_range(0, (open_s < 1800) ? open_s : 1800);
            else
              t = $urandom_range(0, 86399);
          end else begin
            nd = 1'b0;
            r  = $urandom_range(0, 19);
            if (r < 15)      t = t + $urandom_range(0, 600);
            else if (r < 19) t = t + $urandom_range(0, 7200);
          end
          day_left--;
          if (t > LAST_TIME) t = LAST_TIME;
          r = $urandom_range(0, 9);
          if (r < 5)      svc = $urandom_range(0, 30);
          else if (r < 9) svc = $urandom_range(0, 255);
          else            svc = ($urandom_range(0, 1) == 1) ? 255 : 0;
          job.new_day         = nd;
          job.arrive_hour     = 5'(t / 3600);
          job.arrive_minute   = 6'((t % 3600) / 60);
          job.arrive_second   = 6'(t % 60);
          job.service_minutes = 8'(svc);
        end
        push_job(job, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_dispatch_q.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
